/* rtl/shamh_pkg.sv */
// SHA-256 message hasher: shared types, queue sizing, initial hash and round constant tables.
// No dependencies; used by every module of the hasher.
package shamh_pkg;

	// word queue between the byte packer and the compression engine
	localparam int QDEPTH = 16;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// padding marker byte
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;

	// one 32-bit message word plus its block markers
	typedef struct packed {
		word_t data;
		logic  blk_end;  // last word of a 64-byte block
		logic  msg_end;  // block is the final one of the message
	} qword_t;

	// initial hash values H0..H7
	function automatic word_t init_hash(input logic [2:0] idx);
		word_t v;
		case (idx)
			3'd0:    v = 32'h6a09e667;
			3'd1:    v = 32'hbb67ae85;
			3'd2:    v = 32'h3c6ef372;
			3'd3:    v = 32'ha54ff53a;
			3'd4:    v = 32'h510e527f;
			3'd5:    v = 32'h9b05688c;
			3'd6:    v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// round constants K0..K63
	function automatic word_t round_k(input logic [5:0] t);
		word_t v;
		case (t)
			6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;
			default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

endpackage

/* rtl/sha256_message_hasher.sv */
// SHA-256 message hasher top level: front end, word queue and compression engine.
// Depends on shamh_pkg, shamh_front, shamh_queue and shamh_back.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------------------
//  message   | byte_valid / byte_stall    | data_byte[7:0], has_byte, last_byte
//  digest    | digest_valid / digest_stall| digest_word[31:0], word_index[2:0], last_word
//
// Bytes are taken one per cycle while the 16-word queue has room and no padding is under
// way; each full block takes load, 64 rounds (one a cycle, the first 16 only while words
// are queued) and hash add. A last byte stalls input for the padding words, one per cycle
// while the queue has room (up to 18). The digest then leaves as eight words, one per
// cycle unless stalled. Reset restores the initial hash values and empties the queue.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shamh_pkg::*;

	qword_t         q_wr;
	qword_t         q_head;
	logic           q_push;
	logic           q_pop;
	logic           q_empty;
	logic           q_full;
	logic [QCW-1:0] q_count;

	shamh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.last_byte  (last_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wr       (q_wr)
	);

	shamh_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr      (q_wr),
		.pop     (q_pop),
		.head    (q_head),
		.q_empty (q_empty),
		.q_full  (q_full),
		.q_count (q_count)
	);

	shamh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (q_head),
		.pop          (q_pop),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	// front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("word pushed into full queue");

	// engine never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("word popped from empty queue");

	// fill level stays within depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCW'(QDEPTH))
		else $error("queue count out of range");

	// digest words come out in order without gaps
	a_digest_order: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && !last_word) |=>
		(digest_valid && word_index == 3'($past(word_index) + 3'd1)))
		else $error("digest word sequence broken");

	// the digest ends after its eighth word
	a_digest_end: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_valid && !digest_stall && last_word) |=> !digest_valid)
		else $error("digest valid after final word");

endmodule

/* rtl/shamh_front.sv */
// SHA-256 hasher front end: packs bytes into words, appends padding and bit length.
// Depends on shamh_pkg; feeds shamh_queue.
module shamh_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  logic [7:0]      data_byte,
	input  logic            has_byte,
	input  logic            last_byte,
	input  logic            q_full,
	output logic            q_push,
	output shamh_pkg::qword_t q_wr
);
	import shamh_pkg::*;

	typedef enum logic {F_BYTES, F_PAD} fstate_t;

	fstate_t     state_q;
	logic [23:0] part_q;     // partial word, newest byte lowest
	logic [1:0]  bcnt_q;     // bytes in partial word
	logic [3:0]  wcnt_q;     // words pushed in current block
	logic [60:0] total_q;    // message bytes so far
	logic        marked_q;   // 0x80 marker already pushed
	logic        len_blk_q;  // current block carries the length

	logic        accept;
	logic        take;
	logic        word_done;
	logic [3:0]  wcnt_nx;
	logic        pad_exit;
	word_t       marker;

	assign byte_stall = (state_q == F_PAD) || q_full;
	assign accept     = byte_valid && !byte_stall;
	assign take       = accept && has_byte;
	assign word_done  = take && (bcnt_q == 2'd3);
	assign wcnt_nx    = word_done ? wcnt_q + 4'd1 : wcnt_q;
	assign pad_exit   = marked_q && len_blk_q && (wcnt_q == 4'd15);

	// partial bytes followed by the marker and zeros
	always_comb begin
		case (bcnt_q)
			2'd0:    marker = {PAD_BYTE, 24'h0};
			2'd1:    marker = {part_q[7:0], PAD_BYTE, 16'h0};
			2'd2:    marker = {part_q[15:0], PAD_BYTE, 8'h0};
			default: marker = {part_q[23:0], PAD_BYTE};
		endcase
	end

	// word to the queue
	always_comb begin
		q_push     = 1'b0;
		q_wr.data  = '0;
		q_wr.blk_end = (wcnt_q == 4'd15);
		q_wr.msg_end = 1'b0;
		case (state_q)
			F_BYTES: begin
				q_push    = word_done;
				q_wr.data = {part_q, data_byte};
			end
			F_PAD: begin
				q_push = !q_full;
				if (!marked_q) begin
					q_wr.data = marker;
				end else if (len_blk_q && wcnt_q == 4'd14) begin
					q_wr.data = total_q[60:29];
				end else if (len_blk_q && wcnt_q == 4'd15) begin
					q_wr.data    = {total_q[28:0], 3'b000};
					q_wr.msg_end = 1'b1;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// packing and padding sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_BYTES;
			bcnt_q    <= '0;
			wcnt_q    <= '0;
			total_q   <= '0;
			marked_q  <= 1'b0;
			len_blk_q <= 1'b0;
			part_q    <= '0;
		end else begin
			case (state_q)
				F_BYTES: begin
					if (take) begin
						part_q  <= {part_q[15:0], data_byte};
						bcnt_q  <= bcnt_q + 2'd1;
						wcnt_q  <= wcnt_nx;
						total_q <= total_q + 61'd1;
					end
					if (accept && last_byte) begin
						state_q   <= F_PAD;
						marked_q  <= 1'b0;
						// marker past byte 55 spills into a second block
						len_blk_q <= (wcnt_nx[3:1] != 3'b111);
					end
				end
				F_PAD: begin
					if (!q_full) begin
						marked_q <= 1'b1;
						bcnt_q   <= '0;
						wcnt_q   <= wcnt_q + 4'd1;
						if (wcnt_q == 4'd15) begin
							len_blk_q <= 1'b1;
						end
						if (pad_exit) begin
							state_q <= F_BYTES;
							total_q <= '0;
							wcnt_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= F_BYTES;
				end
			endcase
		end
	end

endmodule

/* rtl/shamh_queue.sv */
// SHA-256 hasher word queue between the front end and the compression engine.
// Depends on shamh_pkg.
module shamh_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  shamh_pkg::qword_t wr,
	input  logic              pop,
	output shamh_pkg::qword_t head,
	output logic              q_empty,
	output logic              q_full,
	output logic [shamh_pkg::QCW-1:0] q_count
);
	import shamh_pkg::*;

	qword_t           slot_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == QCW'(QDEPTH));
	assign q_count = count_q;
	assign head    = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !q_full) begin
			slot_q[wr_ptr_q] <= wr;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !q_full) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop && !q_empty) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push && !q_full, pop && !q_empty})
				2'b10:   count_q <= count_q + QCW'(1);
				2'b01:   count_q <= count_q - QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/shamh_back.sv */
// SHA-256 hasher back end: 64-round compression, hash update and digest output.
// Depends on shamh_pkg; reads words from shamh_queue.
module shamh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  shamh_pkg::qword_t head,
	output logic              pop,
	output logic              digest_valid,
	input  logic              digest_stall,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import shamh_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_ADD, B_OUT} bstate_t;

	bstate_t     state_q;
	word_t       hash_q  [8];
	word_t       wv_q    [8];   // a..h
	word_t       sched_q [16];  // index 15 newest
	logic [5:0]  t_q;
	logic        fin_q;
	logic [2:0]  idx_q;

	logic        need_word;
	logic        step;
	word_t       w_in;
	word_t       t1;
	word_t       t2;

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	assign need_word = (t_q[5:4] == 2'b00);
	assign step      = (state_q == B_RUN) && (!need_word || !q_empty);
	assign pop       = step && need_word;

	// schedule word and round sums
	always_comb begin
		if (need_word) begin
			w_in = head.data;
		end else begin
			w_in = (rotr(sched_q[14], 17) ^ rotr(sched_q[14], 19) ^ (sched_q[14] >> 10))
				+ sched_q[9]
				+ (rotr(sched_q[1], 7) ^ rotr(sched_q[1], 18) ^ (sched_q[1] >> 3))
				+ sched_q[0];
		end
		t1 = wv_q[7] + (rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25))
			+ ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
			+ round_k(t_q) + w_in;
		t2 = (rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22))
			+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
	end

	assign digest_valid = (state_q == B_OUT);
	assign digest_word  = hash_q[idx_q];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == 3'd7);

	// working variables and schedule
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !q_empty) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (step) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i + 1];
			end
			sched_q[15] <= w_in;
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	// sequencer and hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			t_q     <= '0;
			fin_q   <= 1'b0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= init_hash(3'(i));
			end
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						t_q     <= '0;
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (step) begin
						t_q <= t_q + 6'd1;
						if (t_q == 6'd15) begin
							fin_q <= head.msg_end;
						end
						if (t_q == 6'd63) begin
							state_q <= B_ADD;
						end
					end
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + wv_q[i];
					end
					idx_q   <= '0;
					state_q <= fin_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (!digest_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= init_hash(3'(i));
							end
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
